// File: hdl/tla_pkg.sv
`default_nettype none

package tla_pkg;

    // index width covers the largest supported list of 64 candidates
    localparam int IDX_W  = 6;
    localparam int POS_W  = 7;
    localparam int SLOT_W = 8;
    localparam int WIN_W  = 5;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [2:0] {
        REASON_NONE    = 3'd0,
        REASON_ONLY    = 3'd1,
        REASON_SCALED  = 3'd2,
        REASON_FOCUS   = 3'd3,
        REASON_INCUMB  = 3'd4,
        REASON_LOWEST  = 3'd5
    } reason_t;

    typedef struct packed {
        logic                     foc_valid;
        logic [IDX_W-1:0]         foc_idx;
        logic                     inc_valid;
        logic [IDX_W-1:0]         inc_idx;
        logic                     slot_valid;
        logic [IDX_W-1:0]         slot_idx;
        logic signed [SLOT_W-1:0] slot_value;
    } grp_status_t;

    localparam grp_status_t GRP_IDLE = '0;

endpackage

`default_nettype wire

// File: hdl/tla_group.sv
`default_nettype none

module tla_group (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             step,
    input  wire logic                             clear,
    input  wire logic                             en,
    input  wire logic [tla_pkg::IDX_W-1:0]        idx,
    input  wire logic                             focused,
    input  wire logic                             incumbent,
    input  wire logic signed [tla_pkg::SLOT_W-1:0] slot,
    output tla_pkg::grp_status_t                  grp_next
);

    tla_pkg::grp_status_t status_reg;

    always_comb begin
        grp_next = status_reg;
        if (en) begin
            if (focused && !status_reg.foc_valid) begin
                grp_next.foc_valid = 1'b1;
                grp_next.foc_idx   = idx;
            end
            if (incumbent && !status_reg.inc_valid) begin
                grp_next.inc_valid = 1'b1;
                grp_next.inc_idx   = idx;
            end
            // strict compare keeps the earlier candidate on a tie
            if (!status_reg.slot_valid || (slot < status_reg.slot_value)) begin
                grp_next.slot_valid = 1'b1;
                grp_next.slot_idx   = idx;
                grp_next.slot_value = slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= tla_pkg::GRP_IDLE;
        end else if (step) begin
            status_reg <= clear ? tla_pkg::GRP_IDLE : grp_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tiered_lease_arbiter_top.sv
`default_nettype none

// Overlay arbiter over a streamed candidate list. Each input word is one candidate;
// tlast marks the final candidate, and only that word produces one output word
// with the winner's list position (-1 when nobody wants the overlay), the reason
// code and an overflow flag. One candidate is accepted every clock cycle while the
// input register is not held; a candidate passes an input register, and the
// trackers and the result register are updated as it leaves it. A last candidate
// waits in the input register while an earlier result word is still unaccepted,
// which holds new candidates too. Candidates past MAX_CANDIDATES are dropped and
// only raise the overflow flag.
module tiered_lease_arbiter_top #(
    parameter int MAX_CANDIDATES = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // wants[0], scaled[1], focused[2], incumbent[3], slot_number[11:4], zero fill
    input  wire logic [tla_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // winner_index[4:0], reason_code[7:5], overflow[8], zero fill
    output      logic [tla_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W  = tla_pkg::IDX_W;
    localparam int POS_W  = tla_pkg::POS_W;
    localparam int SLOT_W = tla_pkg::SLOT_W;
    localparam int WIN_W  = tla_pkg::WIN_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CANDIDATES);

    // input register
    logic                      in_valid_reg;
    logic                      in_wants_reg;
    logic                      in_scaled_reg;
    logic                      in_focused_reg;
    logic                      in_incumbent_reg;
    logic signed [SLOT_W-1:0]  in_slot_reg;
    logic                      in_last_reg;

    // running state
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [1:0]       wanting_count_reg;
    logic [1:0]       wanting_count_next;
    logic [1:0]       scaled_count_reg;
    logic [1:0]       scaled_count_next;
    logic             first_wanting_valid_reg;
    logic             first_wanting_valid_next;
    logic [IDX_W-1:0] first_wanting_reg;
    logic [IDX_W-1:0] first_wanting_next;
    logic             overflowed_reg;
    logic             overflowed_next;

    // output register
    logic             m_valid_reg;
    logic [WIN_W-1:0] win_reg;
    tla_pkg::reason_t reason_reg;
    logic             ovf_reg;

    logic             step;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             take;
    tla_pkg::grp_status_t grp_all;
    tla_pkg::grp_status_t grp_scl;
    tla_pkg::grp_status_t grp_sel;
    logic [IDX_W-1:0] win_idx;
    logic             win_valid;
    tla_pkg::reason_t reason;

    // a non-last word never needs the output register
    assign step     = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_wants_reg     <= s_tdata[0];
            in_scaled_reg    <= s_tdata[1];
            in_focused_reg   <= s_tdata[2];
            in_incumbent_reg <= s_tdata[3];
            in_slot_reg      <= s_tdata[11:4];
            in_last_reg      <= s_tlast;
        end
    end

    assign in_range = position_reg < POS_LIMIT;
    assign idx      = position_reg[IDX_W-1:0];
    assign take     = in_range && in_wants_reg;

    always_comb begin
        position_next            = position_reg;
        wanting_count_next       = wanting_count_reg;
        scaled_count_next        = scaled_count_reg;
        first_wanting_valid_next = first_wanting_valid_reg;
        first_wanting_next       = first_wanting_reg;
        overflowed_next          = overflowed_reg;
        if (!in_range) begin
            overflowed_next = 1'b1;
        end else begin
            position_next = position_reg + 1'b1;
        end
        if (take) begin
            if (wanting_count_reg != 2'd2) begin
                wanting_count_next = wanting_count_reg + 1'b1;
            end
            if (!first_wanting_valid_reg) begin
                first_wanting_valid_next = 1'b1;
                first_wanting_next       = idx;
            end
            if (in_scaled_reg && (scaled_count_reg != 2'd2)) begin
                scaled_count_next = scaled_count_reg + 1'b1;
            end
        end
    end

    tla_group u_grp_all (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .clear     (in_last_reg),
        .en        (take),
        .idx       (idx),
        .focused   (in_focused_reg),
        .incumbent (in_incumbent_reg),
        .slot      (in_slot_reg),
        .grp_next  (grp_all)
    );

    tla_group u_grp_scl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .clear     (in_last_reg),
        .en        (take && in_scaled_reg),
        .idx       (idx),
        .focused   (in_focused_reg),
        .incumbent (in_incumbent_reg),
        .slot      (in_slot_reg),
        .grp_next  (grp_scl)
    );

    // tier decision on the state including the last word
    always_comb begin
        grp_sel   = (scaled_count_next != 2'd0) ? grp_scl : grp_all;
        win_valid = 1'b0;
        win_idx   = '0;
        reason    = tla_pkg::REASON_NONE;
        if (wanting_count_next == 2'd1) begin
            win_valid = first_wanting_valid_next;
            win_idx   = first_wanting_next;
            reason    = tla_pkg::REASON_ONLY;
        end else if (wanting_count_next == 2'd2) begin
            if (grp_sel.foc_valid) begin
                win_valid = 1'b1;
                win_idx   = grp_sel.foc_idx;
                reason    = tla_pkg::REASON_FOCUS;
            end else if (grp_sel.inc_valid) begin
                win_valid = 1'b1;
                win_idx   = grp_sel.inc_idx;
                reason    = tla_pkg::REASON_INCUMB;
            end else begin
                win_valid = grp_sel.slot_valid;
                win_idx   = grp_sel.slot_idx;
                reason    = tla_pkg::REASON_LOWEST;
            end
            if (!win_valid) begin
                reason = tla_pkg::REASON_NONE;
            end else if (scaled_count_next == 2'd1) begin
                reason = tla_pkg::REASON_SCALED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg            <= '0;
            wanting_count_reg       <= '0;
            scaled_count_reg        <= '0;
            first_wanting_valid_reg <= 1'b0;
            overflowed_reg          <= 1'b0;
        end else if (step) begin
            if (in_last_reg) begin
                position_reg            <= '0;
                wanting_count_reg       <= '0;
                scaled_count_reg        <= '0;
                first_wanting_valid_reg <= 1'b0;
                overflowed_reg          <= 1'b0;
            end else begin
                position_reg            <= position_next;
                wanting_count_reg       <= wanting_count_next;
                scaled_count_reg        <= scaled_count_next;
                first_wanting_valid_reg <= first_wanting_valid_next;
                overflowed_reg          <= overflowed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            first_wanting_reg <= first_wanting_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // wide positions wrap to the 5 bit result field
    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            win_reg    <= win_valid ? WIN_W'({{WIN_W{1'b0}}, win_idx}) : {WIN_W{1'b1}};
            reason_reg <= reason;
            ovf_reg    <= overflowed_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, ovf_reg, reason_reg, win_reg};

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_CAND    = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                              wants;
        logic                              scaled;
        logic                              focused;
        logic                              incumbent;
        logic signed [tla_pkg::SLOT_W-1:0] slot;
        logic                              last;
    } candidate_t;

    typedef struct packed {
        logic [tla_pkg::WIN_W-1:0] winner;
        tla_pkg::reason_t          reason;
        logic                      overflow;
    } award_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tla_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tla_pkg::M_TDATA_W-1:0] m_tdata;

    bit     idle_on       = 1'b1;
    int     stall_cycles  = 0;
    int     cycles        = 0;
    int     errors        = 0;
    int     lists_sent    = 0;
    int     cands_sent    = 0;
    int     awards_seen   = 0;
    int     overflow_lists = 0;
    award_t pending_awards[$];

    // running view of the arbiter, group 0 is all wanting, group 1 scaled wanting
    int                                seen_count;
    int                                want_tally;
    int                                scaled_tally;
    int                                first_want;
    int                                first_foc[2];
    int                                first_inc[2];
    int                                low_idx[2];
    logic signed [tla_pkg::SLOT_W-1:0] low_val[2];
    bit                                lost_some;

    tiered_lease_arbiter_top #(
        .MAX_CANDIDATES(MAX_CAND)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_awards.size());
        $display("CHECK FAILED");
        $finish;
    end

    // result side ready, with a counted hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_cycles > 0) begin
                stall_cycles--;
                m_tready <= 1'b0;
            end else if (idle_on) begin
                m_tready <= ($urandom_range(99) >= 33);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void clear_tracking();
        seen_count   = 0;
        want_tally   = 0;
        scaled_tally = 0;
        first_want   = -1;
        lost_some    = 1'b0;
        for (int g = 0; g < 2; g++) begin
            first_foc[g] = -1;
            first_inc[g] = -1;
            low_idx[g]   = -1;
            low_val[g]   = '0;
        end
    endfunction

    function automatic void note_in_group(input int g, input int idx, input candidate_t c);
        if (c.focused && first_foc[g] < 0) begin
            first_foc[g] = idx;
        end
        if (c.incumbent && first_inc[g] < 0) begin
            first_inc[g] = idx;
        end
        // strict less-than keeps the earlier candidate on equal slots
        if (low_idx[g] < 0 || $signed(c.slot) < $signed(low_val[g])) begin
            low_idx[g] = idx;
            low_val[g] = c.slot;
        end
    endfunction

    function automatic void arbitrate_candidate(input candidate_t c);
        award_t a;
        int     g;
        int     pick;
        if (seen_count >= MAX_CAND) begin
            lost_some = 1'b1;
        end else begin
            if (c.wants) begin
                if (want_tally < 2) want_tally++;
                if (first_want < 0) first_want = seen_count;
                note_in_group(0, seen_count, c);
                if (c.scaled) begin
                    if (scaled_tally < 2) scaled_tally++;
                    note_in_group(1, seen_count, c);
                end
            end
            seen_count++;
        end
        if (c.last) begin
            pick     = -1;
            a.reason = tla_pkg::REASON_NONE;
            if (want_tally == 1) begin
                pick     = first_want;
                a.reason = tla_pkg::REASON_ONLY;
            end else if (want_tally >= 2) begin
                g = (scaled_tally > 0) ? 1 : 0;
                if (first_foc[g] >= 0) begin
                    pick     = first_foc[g];
                    a.reason = tla_pkg::REASON_FOCUS;
                end else if (first_inc[g] >= 0) begin
                    pick     = first_inc[g];
                    a.reason = tla_pkg::REASON_INCUMB;
                end else begin
                    pick     = low_idx[g];
                    a.reason = tla_pkg::REASON_LOWEST;
                end
                if (pick < 0) begin
                    a.reason = tla_pkg::REASON_NONE;
                end else if (g == 1 && scaled_tally == 1) begin
                    a.reason = tla_pkg::REASON_SCALED;
                end
            end
            a.winner   = pick[tla_pkg::WIN_W-1:0];
            a.overflow = lost_some;
            pending_awards.push_back(a);
            if (lost_some) overflow_lists++;
            clear_tracking();
        end
    endfunction

    function automatic candidate_t cand(input bit w, input bit s, input bit f, input bit i,
                                        input int slot, input bit last);
        candidate_t c;
        c.wants     = w;
        c.scaled    = s;
        c.focused   = f;
        c.incumbent = i;
        c.slot      = slot[tla_pkg::SLOT_W-1:0];
        c.last      = last;
        return c;
    endfunction

    task automatic send_candidate(input candidate_t c);
        bit ready;
        while (idle_on && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, c.slot, c.incumbent, c.focused, c.scaled, c.wants};
        s_tlast  <= c.last;
        // ready sampled mid-cycle, the word moves at the following edge
        do begin
            @(negedge aclk);
            ready = (s_tready === 1'b1);
            @(posedge aclk);
        end while (!ready);
        arbitrate_candidate(c);
        cands_sent++;
        if (c.last) lists_sent++;
    endtask

    task automatic send_random_list(input int len, input bit narrow_slots);
        candidate_t c;
        for (int k = 0; k < len; k++) begin
            c.wants     = ($urandom_range(99) < 70);
            c.scaled    = ($urandom_range(99) < 25);
            c.focused   = ($urandom_range(99) < 15);
            c.incumbent = ($urandom_range(99) < 15);
            // a narrow slot range makes ties on the last tier likely
            if (narrow_slots) begin
                c.slot = tla_pkg::SLOT_W'($urandom_range(3) - 2);
            end else begin
                c.slot = tla_pkg::SLOT_W'($urandom_range(255));
            end
            c.last = (k == len - 1);
            send_candidate(c);
        end
    endtask

    initial begin : result_check
        logic                          fire;
        logic [tla_pkg::M_TDATA_W-1:0] word;
        award_t                        want;
        forever begin
            @(negedge aclk);
            fire = (m_tvalid === 1'b1) && (m_tready === 1'b1);
            word = m_tdata;
            @(posedge aclk);
            if (fire) begin
                if (pending_awards.size() == 0) begin
                    errors++;
                    $display("%0t: result word %h with none expected", $time, word);
                end else begin
                    want = pending_awards.pop_front();
                    awards_seen++;
                    if (word[4:0] !== want.winner) begin
                        errors++;
                        $display("%0t: winner expected %0d actual %0d", $time,
                                 $signed(want.winner), $signed(word[4:0]));
                    end
                    if (word[7:5] !== want.reason) begin
                        errors++;
                        $display("%0t: reason expected %0d actual %0d", $time,
                                 want.reason, word[7:5]);
                    end
                    if (word[8] !== want.overflow) begin
                        errors++;
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 want.overflow, word[8]);
                    end
                end
            end
        end
    end

    task automatic test_nobody_wants();
        send_candidate(cand(0, 1, 1, 1, 127, 1));
        send_candidate(cand(0, 0, 0, 0, -128, 0));
        send_candidate(cand(0, 1, 0, 1, 0, 1));
    endtask

    task automatic test_sole_candidate();
        send_candidate(cand(0, 1, 1, 0, -128, 0));
        send_candidate(cand(1, 1, 1, 1, 127, 1));
    endtask

    task automatic test_tier_order();
        // focus beats an earlier incumbent and a lower slot
        send_candidate(cand(1, 0, 0, 1, 0, 0));
        send_candidate(cand(1, 0, 0, 0, -128, 0));
        send_candidate(cand(1, 0, 1, 0, 5, 1));
        // incumbent beats a lower slot
        send_candidate(cand(1, 0, 0, 0, -128, 0));
        send_candidate(cand(1, 0, 0, 1, 127, 1));
        // equal lowest slots, the earlier one wins
        send_candidate(cand(1, 0, 0, 0, 127, 0));
        send_candidate(cand(1, 0, 0, 0, -128, 0));
        send_candidate(cand(1, 0, 0, 0, -128, 1));
    endtask

    task automatic test_scaled_group();
        // one scaled rival narrows the group and reports scaled
        send_candidate(cand(1, 0, 1, 0, 0, 0));
        send_candidate(cand(1, 1, 0, 0, 127, 0));
        send_candidate(cand(1, 0, 0, 1, -1, 1));
        // two scaled, decided on slot
        send_candidate(cand(1, 1, 0, 0, 3, 0));
        send_candidate(cand(1, 1, 0, 0, -3, 1));
    endtask

    task automatic test_overflow();
        for (int k = 0; k <= MAX_CAND; k++) begin
            send_candidate(cand(k == 0 || k == MAX_CAND, 0, k == MAX_CAND, 0, k,
                                k == MAX_CAND));
        end
    endtask

    task automatic test_random_lists(input int n_items);
        int start;
        int len;
        int r;
        start = cands_sent;
        while (cands_sent - start < n_items) begin
            // a calm stretch with no idling on either side
            idle_on = !((cands_sent - start > n_items / 3) &&
                        (cands_sent - start < n_items / 2));
            r = $urandom_range(99);
            if (r < 70) begin
                len = $urandom_range(5, 1);
            end else if (r < 92) begin
                len = $urandom_range(MAX_CAND, 6);
            end else begin
                len = $urandom_range(MAX_CAND + 4, MAX_CAND + 1);
            end
            send_random_list(len, 1'($urandom_range(1)));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        idle_on      = 1'b0;
        stall_cycles = 150;
        for (int k = 0; k < 40; k++) begin
            send_random_list(2, 1'b0);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        clear_tracking();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_nobody_wants();
        test_sole_candidate();
        test_tier_order();
        test_scaled_group();
        test_overflow();
        test_random_lists(320);
        test_backpressure();

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_awards.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d candidates in %0d lists, %0d of them overflowing",
                 cands_sent, lists_sent, overflow_lists);
        $display("%0d result words checked, %0d errors", awards_seen, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
